// File: rtl/mtf_pkg.sv
`default_nettype none
package mtf_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;
   localparam int MODE_W = 2;
   localparam int POS_OUT_W = 4;
   localparam int CNT_OUT_W = 5;

   localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] S_IDLE   = 3'd0;
   localparam logic [STEP_W-1:0] S_APPEND = 3'd1;
   localparam logic [STEP_W-1:0] S_CLEAR  = 3'd2;
   localparam logic [STEP_W-1:0] S_SCAN   = 3'd3;
   localparam logic [STEP_W-1:0] S_SHIFT  = 3'd4;
   localparam logic [STEP_W-1:0] S_FRONT  = 3'd5;
   localparam logic [STEP_W-1:0] S_DONE   = 3'd6;

   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] C_NEVER    = 3'd0;
   localparam logic [COND_W-1:0] C_ALWAYS   = 3'd1;
   localparam logic [COND_W-1:0] C_ACCEPT   = 3'd2;
   localparam logic [COND_W-1:0] C_SCAN_END = 3'd3;
   localparam logic [COND_W-1:0] C_MATCH    = 3'd4;
   localparam logic [COND_W-1:0] C_IDX_ZERO = 3'd5;
   localparam logic [COND_W-1:0] C_OUT_FREE = 3'd6;

   localparam logic [1:0] IDX_HOLD     = 2'd0;
   localparam logic [1:0] IDX_ZERO     = 2'd1;
   localparam logic [1:0] IDX_INC_MISS = 2'd2;
   localparam logic [1:0] IDX_DEC      = 2'd3;

   localparam logic [1:0] CNT_HOLD   = 2'd0;
   localparam logic [1:0] CNT_ZERO   = 2'd1;
   localparam logic [1:0] CNT_APPEND = 2'd2;

   localparam logic [1:0] WR_NONE  = 2'd0;
   localparam logic [1:0] WR_SHIFT = 2'd1;
   localparam logic [1:0] WR_FRONT = 2'd2;

   typedef struct packed {
      logic              take;
      logic              map;
      logic [COND_W-1:0] cond_a;
      logic [STEP_W-1:0] tgt_a;
      logic [COND_W-1:0] cond_b;
      logic [STEP_W-1:0] tgt_b;
      logic [STEP_W-1:0] nxt;
      logic [1:0]        idx_op;
      logic [1:0]        cnt_op;
      logic [1:0]        wr_op;
      logic              cap_match;
      logic              out_load;
   } mtf_ctrl_type;

   typedef struct packed {
      logic              accept;
      logic              scan_end;
      logic              match;
      logic              idx_zero;
      logic              out_free;
      logic [MODE_W-1:0] mode;
   } mtf_status_type;

   function automatic mtf_ctrl_type mtf_program(input logic [STEP_W-1:0] step);
      mtf_ctrl_type w;
      w = '{take: 1'b0, map: 1'b0, cond_a: C_NEVER, tgt_a: S_IDLE, cond_b: C_NEVER,
            tgt_b: S_IDLE, nxt: S_IDLE, idx_op: IDX_HOLD, cnt_op: CNT_HOLD,
            wr_op: WR_NONE, cap_match: 1'b0, out_load: 1'b0};
      case (step)
         S_IDLE: begin
            w.take = 1'b1;
            w.map = 1'b1;
            w.cond_a = C_ACCEPT;
            w.nxt = S_IDLE;
            w.idx_op = IDX_ZERO;
         end
         S_APPEND: begin
            w.cond_a = C_ALWAYS;
            w.tgt_a = S_DONE;
            w.cnt_op = CNT_APPEND;
         end
         S_CLEAR: begin
            w.cond_a = C_ALWAYS;
            w.tgt_a = S_DONE;
            w.cnt_op = CNT_ZERO;
         end
         S_SCAN: begin
            w.cond_a = C_SCAN_END;
            w.tgt_a = S_DONE;
            w.cond_b = C_MATCH;
            w.tgt_b = S_SHIFT;
            w.nxt = S_SCAN;
            w.idx_op = IDX_INC_MISS;
            w.cap_match = 1'b1;
         end
         S_SHIFT: begin
            w.cond_a = C_IDX_ZERO;
            w.tgt_a = S_FRONT;
            w.nxt = S_SHIFT;
            w.idx_op = IDX_DEC;
            w.wr_op = WR_SHIFT;
         end
         S_FRONT: begin
            w.cond_a = C_ALWAYS;
            w.tgt_a = S_DONE;
            w.wr_op = WR_FRONT;
         end
         S_DONE: begin
            w.cond_a = C_OUT_FREE;
            w.tgt_a = S_IDLE;
            w.nxt = S_DONE;
            w.out_load = 1'b1;
         end
         default: begin
            w.cond_a = C_ALWAYS;
            w.tgt_a = S_IDLE;
         end
      endcase
      return w;
   endfunction

   function automatic logic mtf_cond(input logic [COND_W-1:0] c, input mtf_status_type s);
      logic r;
      case (c)
         C_ALWAYS:   r = 1'b1;
         C_ACCEPT:   r = s.accept;
         C_SCAN_END: r = s.scan_end;
         C_MATCH:    r = s.match;
         C_IDX_ZERO: r = s.idx_zero;
         C_OUT_FREE: r = s.out_free;
         default:    r = 1'b0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/mtf_sequencer.sv
`default_nettype none
module mtf_sequencer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mtf_pkg::mtf_status_type status,
   output mtf_pkg::mtf_ctrl_type       ctrl
);

   logic [mtf_pkg::STEP_W-1:0] step_ff;
   logic [mtf_pkg::STEP_W-1:0] step_in;
   logic [mtf_pkg::STEP_W-1:0] mode_target;

   assign ctrl = mtf_pkg::mtf_program(step_ff);

   always_comb begin
      case (status.mode)
         mtf_pkg::MODE_APPEND: mode_target = mtf_pkg::S_APPEND;
         mtf_pkg::MODE_SEARCH: mode_target = mtf_pkg::S_SCAN;
         mtf_pkg::MODE_CLEAR:  mode_target = mtf_pkg::S_CLEAR;
         default:              mode_target = mtf_pkg::S_DONE;
      endcase
   end

   always_comb begin
      if (mtf_pkg::mtf_cond(ctrl.cond_a, status)) begin
         step_in = ctrl.map ? mode_target : ctrl.tgt_a;
      end else if (mtf_pkg::mtf_cond(ctrl.cond_b, status)) begin
         step_in = ctrl.tgt_b;
      end else begin
         step_in = ctrl.nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= mtf_pkg::S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/move_to_front_search_list_top.sv
`default_nettype none
// Move-to-front list of up to 16 32-bit entries. Each request word carries a mode in
// req_tuser (0 append, 1 search, 2 clear) and a value in req_tdata, and yields exactly
// one response word. A small microcode program steps a single-port register file
// one entry per cycle. Append and clear run their own step, then the done step; the
// unused mode goes straight to done. A search scans from the front to a match or the
// list end; a hit then shifts earlier entries back via the same port and fronts the key.
// A new request is taken as soon as the previous one has reached the response
// register, even while that response still waits to be taken.
module move_to_front_search_list_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // value[31:0]
   input  wire logic [1:0]  req_tuser,  // mode[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata   // found[0], position[4:1], entry_count[9:5],
                                        // dropped[10], zero[15:11]
);

   localparam int IDX_W = mtf_pkg::IDX_W;
   localparam int CNT_W = mtf_pkg::CNT_W;

   mtf_pkg::mtf_ctrl_type   ctrl;
   mtf_pkg::mtf_status_type status;

   logic [mtf_pkg::VALUE_W-1:0] list_ff [mtf_pkg::DEPTH];
   logic [mtf_pkg::VALUE_W-1:0] key_ff;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            idx_ff, idx_in;
   logic                        found_ff, found_in;
   logic [IDX_W-1:0]            pos_ff, pos_in;
   logic                        dropped_ff, dropped_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [15:0]                 rsp_data_ff, rsp_data_in;

   logic                        accept;
   logic                        full;
   logic [IDX_W-1:0]            rd_addr;
   logic [mtf_pkg::VALUE_W-1:0] rd_data;

   mtf_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   assign req_tready = ctrl.take;
   assign accept = req_tvalid && req_tready;
   assign full = (count_ff == CNT_W'(mtf_pkg::DEPTH));
   assign rd_addr = (ctrl.wr_op == mtf_pkg::WR_SHIFT) ? idx_ff[IDX_W-1:0] - IDX_W'(1)
                                                      : idx_ff[IDX_W-1:0];
   assign rd_data = list_ff[rd_addr];

   always_comb begin
      status.accept = accept;
      status.scan_end = (idx_ff >= count_ff);
      status.match = !status.scan_end && (rd_data == key_ff);
      status.idx_zero = (idx_ff == '0);
      status.out_free = !rsp_valid_ff || rsp_tready;
      status.mode = req_tuser;
   end

   always_comb begin
      idx_in = idx_ff;
      case (ctrl.idx_op)
         mtf_pkg::IDX_ZERO:     idx_in = '0;
         mtf_pkg::IDX_INC_MISS: idx_in = status.match ? idx_ff : idx_ff + CNT_W'(1);
         mtf_pkg::IDX_DEC:      idx_in = idx_ff - CNT_W'(1);
         default:               idx_in = idx_ff;
      endcase

      count_in = count_ff;
      case (ctrl.cnt_op)
         mtf_pkg::CNT_ZERO:   count_in = '0;
         mtf_pkg::CNT_APPEND: count_in = full ? count_ff : count_ff + CNT_W'(1);
         default:             count_in = count_ff;
      endcase

      found_in = found_ff;
      pos_in = pos_ff;
      dropped_in = dropped_ff;
      if (accept) begin
         found_in = 1'b0;
         pos_in = '0;
         dropped_in = 1'b0;
      end
      if (ctrl.cap_match && status.match) begin
         found_in = 1'b1;
         pos_in = idx_ff[IDX_W-1:0];
      end
      if (ctrl.cnt_op == mtf_pkg::CNT_APPEND && full) begin
         dropped_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      if (ctrl.out_load && status.out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = {5'b0, dropped_ff, mtf_pkg::CNT_OUT_W'(count_ff),
                        mtf_pkg::POS_OUT_W'(pos_ff), found_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.cnt_op == mtf_pkg::CNT_APPEND && !full) begin
         list_ff[count_ff[IDX_W-1:0]] <= key_ff;
      end else if (ctrl.wr_op == mtf_pkg::WR_SHIFT && !status.idx_zero) begin
         list_ff[idx_ff[IDX_W-1:0]] <= rd_data;
      end else if (ctrl.wr_op == mtf_pkg::WR_FRONT) begin
         list_ff[0] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= req_tdata;
      end
      idx_ff <= idx_in;
      found_ff <= found_in;
      pos_ff <= pos_in;
      dropped_ff <= dropped_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(mtf_pkg::DEPTH))
      else $error("entry count exceeds list depth");

   a_found_not_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[10]))
      else $error("response both found and dropped");

   a_found_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> ({1'b0, rsp_tdata[4:1]} < rsp_tdata[9:5]))
      else $error("found position outside the valid entries");

   a_miss_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[4:1] == 4'd0))
      else $error("position nonzero without a match");

   a_busy_no_take: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == mtf_pkg::MODE_SEARCH) |=> !req_tready)
      else $error("request taken while a search is running");
`endif

endmodule
`default_nettype wire
